>>> design/rc_channel_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// rc channel frame parser assertion macros
// concurrent assertion forms used by the parser back end
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_FRAME_PARSER_ASSERT_SVH
`define RC_CHANNEL_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled while reset is applied
`define RCFP_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rcfp assertion failed");

// next-cycle implication, disabled while reset is applied
`define RCFP_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rcfp assertion failed");

`endif

>>> design/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp package
// frame layout constants, register codes and shared types
// ----------------------------------------------------------------------------
`default_nettype none

package rcfp_pkg;

	localparam int NUM_CHANNELS_DEF = 14;
	localparam int QUEUE_DEPTH      = 2;

	localparam int BYTE_W    = 8;
	localparam int VALUE_W   = 16;
	localparam int INDEX_W   = 4;
	localparam int POS_W     = 5;
	localparam int CFG_IDX_W = 1;

	// byte positions inside a frame
	localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
	localparam logic [POS_W-1:0] POS_CMD      = 5'd1;
	localparam logic [POS_W-1:0] POS_CH_FIRST = 5'd2;
	localparam logic [POS_W-1:0] POS_CH_LAST  = 5'd29;
	localparam logic [POS_W-1:0] POS_CHK_LO   = 5'd30;
	localparam logic [POS_W-1:0] POS_CHK_HI   = 5'd31;

	localparam logic             CHECK_ENABLE_RST = 1'b1;
	localparam logic [BYTE_W-1:0] SYNC_VALUE_RST  = 8'h20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHECK_ENABLE = 1'b0,
		REG_SYNC_VALUE   = 1'b1
	} cfg_reg_t;

	// per-frame summary handed from front to back
	typedef struct packed {
		logic [BYTE_W-1:0] command;
		logic              crc_err;
	} frame_info_t;

endpackage

`default_nettype wire

>>> design/rcfp_byte_if.sv
// ----------------------------------------------------------------------------
// rcfp byte channel
// valid/ready channel carrying one received serial byte
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfp_byte_if;
	import rcfp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/rcfp_result_if.sv
// ----------------------------------------------------------------------------
// rcfp result channel
// valid/ready channel carrying one decoded channel result
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfp_result_if;
	import rcfp_pkg::*;

	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] channel_index;
	logic [VALUE_W-1:0] channel_value;
	logic [BYTE_W-1:0]  command_byte;
	logic               status;
	logic               last;

	modport source (output valid, output channel_index, output channel_value,
		output command_byte, output status, output last, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input command_byte, input status, input last, output ready);
endinterface

`default_nettype wire

>>> design/rcfp_cfg_if.sv
// ----------------------------------------------------------------------------
// rcfp configuration channel
// valid/ready register write channel: register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface rcfp_cfg_if;
	import rcfp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output reg_index, output data, input ready);
	modport sink (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

>>> design/rc_channel_frame_parser.sv
// ----------------------------------------------------------------------------
// rc channel frame parser
// serial radio-control frame decoder: 32-byte frames to channel results
// ----------------------------------------------------------------------------
// usage
//   rx     : one received byte per transaction; the parser hunts for the sync
//            byte, then collects command, channel bytes and checksum
//   result : one transaction per channel (index 0 upward, last on the final
//            one), or one transaction with status 1 on a checksum mismatch
//   cfg    : register writes, always ready; 0 = check enable, 1 = sync value
// timing
//   a byte is taken every cycle unless a closing byte meets a full queue;
//   a closing byte is pushed into the two-frame queue, and the first result
//   passes the queue and the output register; a good frame then streams one
//   result per cycle while ready is high, set by the single output register
// reset
//   parser hunts for sync, checksum checking on, sync value 0x20, queue and
//   output register empty; the channel store is not cleared
// stall
//   results hold in the output register while ready is low; bytes keep
//   flowing until a closing byte finds both queue slots full
// ----------------------------------------------------------------------------
`default_nettype none

module rc_channel_frame_parser #(
	parameter int NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	rcfp_byte_if.sink      rx,
	rcfp_cfg_if.sink       cfg,
	rcfp_result_if.source  result
);
	import rcfp_pkg::*;

	localparam int CHANS_W = NUM_CHANNELS * VALUE_W;
	localparam int ENTRY_W = CHANS_W + $bits(frame_info_t);

	// front to queue
	logic               push_valid;
	logic               push_ready;
	frame_info_t        push_info;
	logic [CHANS_W-1:0] push_chans;

	// queue to back
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;
	frame_info_t        pop_info;
	logic [CHANS_W-1:0] pop_chans;

	// sync hunt, checksum and channel capture
	rcfp_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_info  (push_info),
		.push_chans (push_chans)
	);

	// completed frames wait here so the input waits on the output only when the queue is full
	rcfp_queue #(
		.W(ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({push_info, push_chans}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	assign pop_info  = frame_info_t'(pop_data[ENTRY_W-1:CHANS_W]);
	assign pop_chans = pop_data[CHANS_W-1:0];

	// result sequencing and output register
	rcfp_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_pop   (pop_ready),
		.q_info  (pop_info),
		.q_chans (pop_chans),
		.result  (result)
	);
endmodule

`default_nettype wire

>>> design/rcfp_front.sv
// ----------------------------------------------------------------------------
// rcfp front end
// sync hunt, byte position tracking, checksum and channel capture
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_front #(
	parameter int NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	rcfp_byte_if.sink                                      rx,
	rcfp_cfg_if.sink                                       cfg,
	output logic                                           push_valid,
	input  wire logic                                      push_ready,
	output rcfp_pkg::frame_info_t                          push_info,
	output logic [NUM_CHANNELS*rcfp_pkg::VALUE_W-1:0]      push_chans
);
	import rcfp_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [POS_W-1:0]   pos_q;
	logic [VALUE_W-1:0] sum_q;
	logic [BYTE_W-1:0]  low_q;
	logic [BYTE_W-1:0]  cmd_q;
	logic [BYTE_W-1:0]  chk_lo_q;
	logic               check_en_q;
	logic [BYTE_W-1:0]  sync_q;
	logic [VALUE_W-1:0] store_q [NUM_CHANNELS];

	logic               accept;
	logic               in_chan;
	logic [INDEX_W-1:0] ch_pos;
	logic               ch_wr;
	logic [VALUE_W-1:0] chk_got;

	// only the closing byte needs room in the queue
	assign rx.ready  = !((pos_q == POS_CHK_HI) && !push_ready);
	assign cfg.ready = 1'b1;
	assign accept    = rx.valid && rx.ready;

	assign in_chan = (pos_q >= POS_CH_FIRST) && (pos_q <= POS_CH_LAST);
	assign ch_pos  = pos_q[POS_W-1:1] - INDEX_W'(1);
	assign ch_wr   = accept && in_chan && pos_q[0] && (ch_pos < INDEX_W'(NUM_CHANNELS));
	assign chk_got = {rx.rx_byte, chk_lo_q};

	assign push_valid        = accept && (pos_q == POS_CHK_HI);
	assign push_info.command = cmd_q;
	assign push_info.crc_err = check_en_q && (chk_got != ~sum_q);

	always_comb begin
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			push_chans[k*VALUE_W +: VALUE_W] = store_q[k];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_en_q <= CHECK_ENABLE_RST;
			sync_q     <= SYNC_VALUE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.reg_index))
				REG_CHECK_ENABLE: check_en_q <= cfg.data[0];
				REG_SYNC_VALUE:   sync_q     <= cfg.data;
				default:          ;
			endcase
		end
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HUNT;
			sum_q    <= '0;
			low_q    <= '0;
			cmd_q    <= '0;
			chk_lo_q <= '0;
		end else if (accept) begin
			if (pos_q == POS_HUNT) begin
				if (rx.rx_byte == sync_q) begin
					sum_q <= VALUE_W'(rx.rx_byte);
					pos_q <= POS_CMD;
				end
			end else begin
				if (pos_q < POS_CHK_LO) begin
					sum_q <= sum_q + VALUE_W'(rx.rx_byte);
				end
				if (pos_q == POS_CMD) begin
					cmd_q <= rx.rx_byte;
				end else if (in_chan && !pos_q[0]) begin
					low_q <= rx.rx_byte;
				end else if (pos_q == POS_CHK_LO) begin
					chk_lo_q <= rx.rx_byte;
				end
				// wraps from the closing byte back to hunting
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// channel store, no reset
	always_ff @(posedge clk) begin
		if (ch_wr) begin
			store_q[ch_pos[CH_W-1:0]] <= {rx.rx_byte, low_q};
		end
	end
endmodule

`default_nettype wire

>>> design/rcfp_queue.sv
// ----------------------------------------------------------------------------
// rcfp frame queue
// short fifo of completed frames between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rcfp_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_ready,
	output logic [W-1:0]      pop_data
);
	import rcfp_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

`default_nettype wire

>>> design/rcfp_back.sv
// ----------------------------------------------------------------------------
// rcfp back end
// walks a queued frame and emits its channel results, or one error result
// ----------------------------------------------------------------------------
`default_nettype none
`include "rc_channel_frame_parser_assert.svh"

module rcfp_back #(
	parameter int NUM_CHANNELS = rcfp_pkg::NUM_CHANNELS_DEF
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        q_valid,
	output logic                                             q_pop,
	input  wire rcfp_pkg::frame_info_t                       q_info,
	input  wire logic [NUM_CHANNELS*rcfp_pkg::VALUE_W-1:0]   q_chans,
	rcfp_result_if.source                                    result
);
	import rcfp_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [CH_W-1:0]    idx_q;
	logic               out_valid_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [BYTE_W-1:0]  out_cmd_q;
	logic               out_status_q;
	logic               out_last_q;

	logic [VALUE_W-1:0] chan_arr [NUM_CHANNELS];
	logic               load;
	logic               cur_last;

	always_comb begin
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			chan_arr[k] = q_chans[k*VALUE_W +: VALUE_W];
		end
	end

	assign load     = q_valid && (!out_valid_q || result.ready);
	assign cur_last = q_info.crc_err || (idx_q == CH_W'(NUM_CHANNELS - 1));
	assign q_pop    = load && cur_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= cur_last ? '0 : idx_q + CH_W'(1);
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_index_q  <= q_info.crc_err ? '0 : INDEX_W'(idx_q);
			out_value_q  <= q_info.crc_err ? '0 : chan_arr[idx_q];
			out_cmd_q    <= q_info.command;
			out_status_q <= q_info.crc_err;
			out_last_q   <= cur_last;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.channel_index = out_index_q;
	assign result.channel_value = out_value_q;
	assign result.command_byte  = out_cmd_q;
	assign result.status        = out_status_q;
	assign result.last          = out_last_q;

	`RCFP_ASSERT_IMP(a_err_single, clk, arst_n, out_valid_q && out_status_q,
		out_last_q && (out_index_q == '0) && (out_value_q == '0))
	`RCFP_ASSERT_IMP(a_index_range, clk, arst_n, out_valid_q,
		out_index_q < INDEX_W'(NUM_CHANNELS))
	`RCFP_ASSERT_IMP(a_last_at_end, clk, arst_n, out_valid_q && out_last_q && !out_status_q,
		out_index_q == INDEX_W'(NUM_CHANNELS - 1))
	`RCFP_ASSERT_NXT(a_pop_rewinds, clk, arst_n, q_pop, idx_q == '0)
endmodule

`default_nettype wire

>>> sim/rc_channel_frame_parser_test.sv
// ----------------------------------------------------------------------------
// rc channel frame parser testbench
// feeds received bytes (noise, well-formed, corrupted and cut-short frames)
// under several register settings, predicts the channel results of each frame
// and checks every result transaction field by field against the prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rc_channel_frame_parser_test;
	import rcfp_pkg::*;

	localparam int NCH           = NUM_CHANNELS_DEF;
	localparam int FRAME_SLOTS   = 14;	// channel slots carried in every frame
	localparam int SETTLE_CYCLES = 40;	// quiet time before a register write / end

	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC} fill_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic [BYTE_W-1:0]  command;
		logic               status;
		logic               last;
	} chan_result_t;

	logic clk;
	logic arst_n;

	rcfp_byte_if   rx_ch ();
	rcfp_cfg_if    cfg_ch ();
	rcfp_result_if result_ch ();

	rc_channel_frame_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	// bytes waiting to be sent, and channel results waiting to be seen
	logic [BYTE_W-1:0] rx_pending[$];
	chan_result_t      expected_channels[$];

	// idle rates in percent for the byte sender and the result receiver
	int send_idle_pct = 23;
	int recv_idle_pct = 87;
	int errors        = 0;
	int gen_count     = 0;

	// sync value as last written, used when building frames
	logic [BYTE_W-1:0] tx_sync = SYNC_VALUE_RST;

	// predictor copy of the parser registers and frame state
	logic               chk_on    = CHECK_ENABLE_RST;
	logic [BYTE_W-1:0]  sync_byte = SYNC_VALUE_RST;
	logic [POS_W-1:0]   frame_pos = POS_HUNT;
	logic [VALUE_W-1:0] frame_sum = '0;
	logic [BYTE_W-1:0]  low_half  = '0;
	logic [BYTE_W-1:0]  frame_cmd = '0;
	logic [BYTE_W-1:0]  chk_low   = '0;
	logic [VALUE_W-1:0] chan_vals [FRAME_SLOTS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit: far beyond the slowest legal run
	initial begin
		#20ms;
		$display("*** FAILED ***");
		$finish;
	end

	// advance the frame state by one accepted byte; queue any channel results
	task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b);
		logic [VALUE_W-1:0] got;
		logic [VALUE_W-1:0] want;
		chan_result_t       r;
		int                 slot;
		if (frame_pos == POS_HUNT) begin
			// hunting: anything but the sync byte is dropped
			if (b == sync_byte) begin
				frame_sum = VALUE_W'(b);
				frame_pos = POS_CMD;
			end
		end else begin
			// checksum covers sync, command and channel bytes only
			if (frame_pos < POS_CHK_LO)
				frame_sum = frame_sum + VALUE_W'(b);
			if (frame_pos == POS_CMD) begin
				frame_cmd = b;
			end else if (frame_pos <= POS_CH_LAST) begin
				if (!frame_pos[0]) begin
					low_half = b;
				end else begin
					slot = int'(frame_pos - POS_CH_FIRST) >> 1;
					chan_vals[slot] = {b, low_half};
				end
			end else if (frame_pos == POS_CHK_LO) begin
				chk_low = b;
			end

			if (frame_pos != POS_CHK_HI) begin
				frame_pos = frame_pos + POS_W'(1);
			end else begin
				// closing byte: one error result, or every channel in order
				frame_pos = POS_HUNT;
				got  = {b, chk_low};
				want = 16'hFFFF - frame_sum;
				if (chk_on && got != want) begin
					r = '{index: '0, value: '0, command: frame_cmd, status: 1'b1,
						last: 1'b1};
					expected_channels.push_back(r);
				end else begin
					for (int k = 0; k < NCH; k++) begin
						r = '{index: INDEX_W'(k), value: chan_vals[k], command: frame_cmd,
							status: 1'b0, last: (k == NCH - 1)};
						expected_channels.push_back(r);
					end
				end
			end
		end
	endtask

	// byte driver; also tracks register writes so the predictor sees them
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				absorb_rx_byte(rx_ch.rx_byte);
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.reg_index)
					REG_CHECK_ENABLE: chk_on = cfg_ch.data[0];
					REG_SYNC_VALUE: sync_byte = cfg_ch.data;
					default: ;
				endcase
			end
			// next byte once the current transaction is done, with random gaps
			if (!rx_ch.valid || rx_ch.ready) begin
				if (rx_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= rx_pending.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		chan_result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_channels.size() == 0) begin
					$error("result transaction with no result expected: index %0d value %0h",
						result_ch.channel_index, result_ch.channel_value);
					errors++;
				end else begin
					want = expected_channels.pop_front();
					if (result_ch.channel_index !== want.index) begin
						$error("channel_index: expected %0d, got %0d", want.index,
							result_ch.channel_index);
						errors++;
					end
					if (result_ch.channel_value !== want.value) begin
						$error("channel_value: expected %0h, got %0h", want.value,
							result_ch.channel_value);
						errors++;
					end
					if (result_ch.command_byte !== want.command) begin
						$error("command_byte: expected %0h, got %0h", want.command,
							result_ch.command_byte);
						errors++;
					end
					if (result_ch.status !== want.status) begin
						$error("status: expected %0b, got %0b", want.status, result_ch.status);
						errors++;
					end
					if (result_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result_ch.last);
						errors++;
					end
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		rx_pending.push_back(b);
		gen_count++;
	endtask

	// whole frame with the current sync byte; flip != 0 spoils the checksum
	task automatic queue_frame(input logic [BYTE_W-1:0] cmd, input fill_t fill,
		input logic [VALUE_W-1:0] flip);
		logic [VALUE_W-1:0] sum;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] chk;
		sum = VALUE_W'(tx_sync) + VALUE_W'(cmd);
		queue_byte(tx_sync);
		queue_byte(cmd);
		for (int k = 0; k < FRAME_SLOTS; k++) begin
			case (fill)
				FILL_ZERO: v = '0;
				FILL_ONES: v = '1;
				FILL_SYNC: v = {tx_sync, tx_sync};
				default: begin
					// mostly random values, now and then the extremes
					if ($urandom_range(3) == 0)
						v = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
					else
						v = VALUE_W'($urandom);
				end
			endcase
			queue_byte(v[7:0]);
			queue_byte(v[15:8]);
			sum = sum + VALUE_W'(v[7:0]) + VALUE_W'(v[15:8]);
		end
		chk = (16'hFFFF - sum) ^ flip;
		queue_byte(chk[7:0]);
		queue_byte(chk[15:8]);
	endtask

	// mostly good frames with random content, the rest noise and broken frames
	task automatic queue_random_traffic(input int n_bytes);
		int start;
		int pick;
		int n;
		start = gen_count;
		while (gen_count - start < n_bytes) begin
			pick = $urandom_range(99);
			if (pick < 65) begin
				queue_frame(BYTE_W'($urandom), FILL_RANDOM, '0);
			end else if (pick < 70) begin
				queue_frame(tx_sync, FILL_SYNC, '0);
			end else if (pick < 82) begin
				queue_frame(BYTE_W'($urandom), FILL_RANDOM, VALUE_W'($urandom_range(1, 65535)));
			end else if (pick < 92) begin
				n = $urandom_range(1, 4);
				repeat (n) queue_byte(BYTE_W'($urandom));
			end else begin
				// frame cut short: the next frame's bytes finish it off
				n = $urandom_range(1, 30);
				queue_byte(tx_sync);
				repeat (n) queue_byte(BYTE_W'($urandom));
			end
		end
	endtask

	// all bytes taken, all results seen, then let the parser settle
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (rx_pending.size() != 0 || rx_ch.valid || expected_channels.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.data      <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_SYNC_VALUE)
			tx_sync = val;
	endtask

	initial begin
		rx_ch.valid      = 1'b0;
		rx_ch.rx_byte    = '0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.reg_index = REG_CHECK_ENABLE;
		cfg_ch.data      = '0;
		result_ch.ready  = 1'b0;
		for (int k = 0; k < FRAME_SLOTS; k++)
			chan_vals[k] = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed, reset settings: non-sync bytes while hunting are dropped
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h1F);
		queue_byte(8'h21);
		queue_frame(8'h40, FILL_ZERO, '0);
		queue_frame(8'hFF, FILL_ONES, '0);
		// sync byte inside the frame is plain data
		queue_frame(8'h20, FILL_SYNC, '0);
		// checksum wrong in the low byte, then in the high byte
		queue_frame(8'h00, FILL_RANDOM, 16'h0001);
		queue_frame(8'h7F, FILL_RANDOM, 16'h8000);
		wait_quiet();

		// checking off: a bad checksum still gives the channels
		write_reg(REG_CHECK_ENABLE, 8'h00);
		queue_frame(8'h55, FILL_RANDOM, 16'hFFFF);
		wait_quiet();

		// sync value extremes, each frame after a non-sync byte; old sync 0x20 is now noise
		write_reg(REG_CHECK_ENABLE, 8'h01);
		write_reg(REG_SYNC_VALUE, 8'hFF);
		queue_byte(8'h20);
		queue_frame(8'hAA, FILL_RANDOM, '0);
		wait_quiet();
		write_reg(REG_SYNC_VALUE, 8'h00);
		queue_byte(8'h01);
		queue_frame(8'h01, FILL_ZERO, '0);
		wait_quiet();

		// random phases: sender mostly busy, then receiver, then no idling
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 23;
					recv_idle_pct = 87;
				end
				1: begin
					send_idle_pct = 87;
					recv_idle_pct = 23;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_reg(REG_CHECK_ENABLE, (ph == 1) ? 8'h00 : 8'h01);
			write_reg(REG_SYNC_VALUE, (ph == 0) ? SYNC_VALUE_RST : BYTE_W'($urandom));
			queue_random_traffic(56);
			wait_quiet();
		end

		if (errors == 0 && expected_channels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> rc_channel_frame_parser.f
+incdir+design
design/rcfp_pkg.sv
design/rcfp_byte_if.sv
design/rcfp_result_if.sv
design/rcfp_cfg_if.sv
design/rcfp_front.sv
design/rcfp_queue.sv
design/rcfp_back.sv
design/rc_channel_frame_parser.sv
sim/rc_channel_frame_parser_test.sv
